/* rtl/plkt_pkg.sv */
// ----------------------------------------------------------------------------
// plkt_pkg
// Shared types and constants for the parent-linked key table.
// ----------------------------------------------------------------------------
package plkt_pkg;

   localparam int KEY_W    = 32;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 3;
   localparam int LIMIT_W  = 5;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT   = 2'd0,
      OP_DELETE   = 2'd1,
      OP_FIND     = 2'd2,
      OP_CHILDREN = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK             = 3'd0,
      ST_DUPLICATE      = 3'd1,
      ST_PARENT_MISSING = 3'd2,
      ST_FULL           = 3'd3,
      ST_HAS_CHILDREN   = 3'd4,
      ST_NOT_FOUND      = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_COMPARE,
      S_RESOLVE,
      S_CHILD
   } state_type;

   typedef struct packed {
      op_type           op;
      logic [KEY_W-1:0] entry_key;
      logic [KEY_W-1:0] parent_key;
      logic [KEY_W-1:0] info_word;
   } cmd_type;

   typedef struct packed {
      status_type       status;
      logic [KEY_W-1:0] out_key;
      logic [KEY_W-1:0] out_parent;
      logic [KEY_W-1:0] out_info;
      logic             last;
   } rsp_type;

endpackage

/* rtl/plkt_front.sv */
// ----------------------------------------------------------------------------
// plkt_front
// Request intake: decodes the operation and buffers commands in a
// two-entry queue ahead of the table engine.
// ----------------------------------------------------------------------------
module plkt_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic [plkt_pkg::OP_W-1:0]  operation,
   input  logic [plkt_pkg::KEY_W-1:0] entry_key,
   input  logic [plkt_pkg::KEY_W-1:0] parent_key,
   input  logic [plkt_pkg::KEY_W-1:0] info_word,
   output logic                       cmd_valid,
   output plkt_pkg::cmd_type          cmd,
   input  logic                       cmd_pop
);
   import plkt_pkg::*;

   cmd_type    slot_ff [2];
   cmd_type    new_cmd;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       push, pop;

   assign in_ready  = (fill_ff != 2'd2);
   assign cmd_valid = (fill_ff != 2'd0);
   assign cmd       = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = cmd_pop && cmd_valid;

   always_comb begin
      new_cmd.op         = op_type'(operation);
      new_cmd.entry_key  = entry_key;
      new_cmd.parent_key = parent_key;
      new_cmd.info_word  = info_word;
   end

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

/* rtl/plkt_engine.sv */
// ----------------------------------------------------------------------------
// plkt_engine
// Table storage with parallel key/parent compare, command sequencer and
// registered response stage.
// ----------------------------------------------------------------------------
module plkt_engine #(
   parameter int CAPACITY = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         cmd_valid,
   input  plkt_pkg::cmd_type            cmd,
   output logic                         cmd_pop,
   input  logic [plkt_pkg::LIMIT_W-1:0] table_limit,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output plkt_pkg::rsp_type            rsp
);
   import plkt_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;

   // entry storage, compared in parallel
   logic [KEY_W-1:0]    key_ff  [CAPACITY];
   logic [KEY_W-1:0]    par_ff  [CAPACITY];
   logic [KEY_W-1:0]    info_ff [CAPACITY];
   logic [CW-1:0]       count_ff, count_in;

   state_type           st_ff, st_in;
   cmd_type             cmd_ff, cmd_in;
   logic [CAPACITY-1:0] key_hit_ff, key_hit_in;
   logic [CAPACITY-1:0] aux_ff, aux_in, aux_match, child_rest;

   logic                rsp_valid_ff;
   rsp_type             rsp_ff, rsp_in;
   logic                load, out_free;

   logic [IW-1:0]       hit_idx, child_idx, last_idx, rd_idx, wr_idx;
   logic                wr_en, full;
   logic [KEY_W-1:0]    wr_key, wr_par, wr_info, rd_key, rd_par, rd_info;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // compare: key hits, and the op-dependent auxiliary match
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         logic live;
         live = (CW'(i) < count_ff);
         key_hit_in[i] = live && (key_ff[i] == cmd_ff.entry_key);
         unique case (cmd_ff.op)
            OP_INSERT:   aux_match[i] = live && (key_ff[i] == cmd_ff.parent_key);
            OP_DELETE:   aux_match[i] = live && (par_ff[i] == cmd_ff.entry_key);
            OP_FIND:     aux_match[i] = 1'b0;
            OP_CHILDREN: aux_match[i] = live && (par_ff[i] == cmd_ff.parent_key);
            default:     aux_match[i] = 1'b0;
         endcase
      end
   end

   // lowest-index hit comes out of each encoder
   always_comb begin
      hit_idx   = '0;
      child_idx = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (key_hit_ff[i]) hit_idx = IW'(i);
         if (aux_ff[i])     child_idx = IW'(i);
      end
   end

   assign child_rest = aux_ff & ~({{(CAPACITY-1){1'b0}}, 1'b1} << child_idx);
   assign last_idx   = IW'(count_ff - CW'(1));
   assign full       = (LW'(count_ff) >= LW'(table_limit)) || (count_ff == CW'(CAPACITY));

   // single read port
   always_comb begin
      if (st_ff == S_CHILD) begin
         rd_idx = child_idx;
      end else if (cmd_ff.op == OP_DELETE) begin
         rd_idx = last_idx;
      end else begin
         rd_idx = hit_idx;
      end
      rd_key  = key_ff[rd_idx];
      rd_par  = par_ff[rd_idx];
      rd_info = info_ff[rd_idx];
   end

   // next state
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         S_IDLE:    if (cmd_valid) st_in = S_COMPARE;
         S_COMPARE: st_in = S_RESOLVE;
         S_RESOLVE: begin
            if (out_free) begin
               st_in = (cmd_ff.op == OP_CHILDREN && aux_ff != '0) ? S_CHILD : S_IDLE;
            end
         end
         S_CHILD:   if (out_free && child_rest == '0) st_in = S_IDLE;
         default:   st_in = S_IDLE;
      endcase
   end

   // datapath control
   always_comb begin
      cmd_pop  = 1'b0;
      cmd_in   = cmd_ff;
      aux_in   = aux_ff;
      count_in = count_ff;
      load     = 1'b0;
      wr_en    = 1'b0;
      wr_idx   = IW'(count_ff);
      wr_key   = cmd_ff.entry_key;
      wr_par   = cmd_ff.parent_key;
      wr_info  = cmd_ff.info_word;
      rsp_in   = '{status: ST_OK, out_key: '0, out_parent: '0, out_info: '0, last: 1'b1};
      unique case (st_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               cmd_in  = cmd;
            end
         end
         S_COMPARE: aux_in = aux_match;
         S_RESOLVE: begin
            if (out_free) begin
               unique case (cmd_ff.op)
                  OP_INSERT: begin
                     load = 1'b1;
                     priority if (full) begin
                        rsp_in.status = ST_FULL;
                     end else if (key_hit_ff != '0) begin
                        rsp_in.status = ST_DUPLICATE;
                     end else if (cmd_ff.parent_key != '0 && aux_ff == '0) begin
                        rsp_in.status = ST_PARENT_MISSING;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  OP_DELETE: begin
                     load = 1'b1;
                     priority if (aux_ff != '0) begin
                        rsp_in.status = ST_HAS_CHILDREN;
                     end else if (key_hit_ff == '0) begin
                        rsp_in.status = ST_NOT_FOUND;
                     end else begin
                        // last entry fills the hole
                        wr_en    = 1'b1;
                        wr_idx   = hit_idx;
                        wr_key   = rd_key;
                        wr_par   = rd_par;
                        wr_info  = rd_info;
                        count_in = count_ff - CW'(1);
                     end
                  end
                  OP_FIND: begin
                     load = 1'b1;
                     if (key_hit_ff != '0) begin
                        rsp_in.out_key    = rd_key;
                        rsp_in.out_parent = rd_par;
                        rsp_in.out_info   = rd_info;
                     end else begin
                        rsp_in.status = ST_NOT_FOUND;
                     end
                  end
                  OP_CHILDREN: begin
                     if (aux_ff == '0) begin
                        load          = 1'b1;
                        rsp_in.status = ST_NOT_FOUND;
                     end
                  end
                  default: load = 1'b0;
               endcase
            end
         end
         S_CHILD: begin
            if (out_free) begin
               load              = 1'b1;
               aux_in            = child_rest;
               rsp_in.out_key    = rd_key;
               rsp_in.out_parent = cmd_ff.parent_key;
               rsp_in.out_info   = rd_info;
               rsp_in.last       = (child_rest == '0);
            end
         end
         default: cmd_pop = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff    <= st_in;
         count_ff <= count_in;
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      key_hit_ff <= key_hit_in;
      aux_ff     <= aux_in;
      if (load) begin
         rsp_ff <= rsp_in;
      end
      if (wr_en) begin
         key_ff[wr_idx]  <= wr_key;
         par_ff[wr_idx]  <= wr_par;
         info_ff[wr_idx] <= wr_info;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count beyond capacity");

   a_child_pending: assert property (@(posedge clock) disable iff (reset)
      st_ff == S_CHILD |-> aux_ff != '0)
      else $error("child walk with no children left");

   a_partial_in_walk: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.last |-> st_ff == S_CHILD && rsp_ff.status == ST_OK)
      else $error("non-final response outside child walk");

endmodule

/* rtl/parent_linked_key_table.sv */
// Path: a request is queued in the front, then taken through the engine's dequeue,
//   compare and resolve states into the response register; a busy output stalls resolve.
// Find-children then returns one child per cycle while the response register is free.
// The compare is a parallel match over all entries; the single table read port and
//   the one-at-a-time sequencer mean a new request is dequeued only after the last is done.
// Reset: table empty, table_limit 16, no clearing pass; entries are undefined until written.
// ----------------------------------------------------------------------------
// parent_linked_key_table
// Fixed-capacity key table with parent links: insert, delete, find and
// find-children. Front queue decouples intake from the table engine.
// ----------------------------------------------------------------------------
module parent_linked_key_table #(
   parameter int CAPACITY = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [3*plkt_pkg::KEY_W-1:0] req_tdata,  // entry_key, parent_key, info_word
   input  logic [plkt_pkg::OP_W-1:0]    req_tuser,  // operation
   // response channel
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [3*plkt_pkg::KEY_W-1:0] rsp_tdata,  // out_key, out_parent, out_info
   output logic [plkt_pkg::STATUS_W-1:0] rsp_tuser, // status
   output logic                         rsp_tlast,  // last result of this request
   // table_limit register write
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [plkt_pkg::LIMIT_W-1:0] csr_data
);
   import plkt_pkg::*;

   logic [LIMIT_W-1:0] table_limit_ff, table_limit_in;
   logic               cmd_valid, cmd_pop;
   cmd_type            cmd;
   rsp_type            rsp;

   // config writes are to be issued only while idle (not enforced here); always ready
   assign csr_ready      = 1'b1;
   assign table_limit_in = (csr_valid && csr_ready) ? csr_data : table_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         table_limit_ff <= LIMIT_RESET;
      end else begin
         table_limit_ff <= table_limit_in;
      end
   end

   // front: decode and queue each request transaction
   plkt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .operation  (req_tuser),
      .entry_key  (req_tdata[KEY_W-1:0]),
      .parent_key (req_tdata[2*KEY_W-1:KEY_W]),
      .info_word  (req_tdata[3*KEY_W-1:2*KEY_W]),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop)
   );

   // back: compare, update and respond
   plkt_engine #(
      .CAPACITY (CAPACITY)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd),
      .cmd_pop     (cmd_pop),
      .table_limit (table_limit_ff),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp         (rsp)
   );

   // response packing, first field lowest
   assign rsp_tdata = {rsp.out_info, rsp.out_parent, rsp.out_key};
   assign rsp_tuser = rsp.status;
   assign rsp_tlast = rsp.last;

endmodule

/* tb/parent_linked_key_table_tb.sv */
// ----------------------------------------------------------------------------
// parent_linked_key_table_tb
// Self-checking bench for the parent-linked key table. A table model mirrors
// the stored entries and the limit. It predicts the status and the returned
// entries of every accepted request transaction, and each response
// transaction is checked field by field against the oldest prediction.
// The bench runs a directed opening, then random phases under several limits,
// with random idling on both streams and one long response back-pressure.
// ----------------------------------------------------------------------------
module parent_linked_key_table_tb;
   import plkt_pkg::*;

   localparam int TABLE_DEPTH = 16;
   localparam int KEY_POOL    = 24;   // small key space so hits are common
   localparam int PHASE_ITEMS = 31;
   localparam int HOLD_CYCLES = 400;  // long response stall, fills the block
   localparam int DRAIN_WAIT  = 20;   // tail cycles after the last response

   // one predicted response transaction
   typedef struct {
      status_type       status;
      logic [KEY_W-1:0] key;
      logic [KEY_W-1:0] parent;
      logic [KEY_W-1:0] info;
      logic             last;
   } table_reply_type;

   // -------------------------------------------------------------------------
   // Table model and response checker
   // -------------------------------------------------------------------------
   class table_scoreboard_type;
      logic [KEY_W-1:0] keys    [TABLE_DEPTH];
      logic [KEY_W-1:0] parents [TABLE_DEPTH];
      logic [KEY_W-1:0] infos   [TABLE_DEPTH];
      int unsigned      count;
      int unsigned      limit;
      table_reply_type  replies_q[$];
      int unsigned      errors;

      function new();
         count  = 0;
         limit  = LIMIT_RESET;
         errors = 0;
      endfunction

      function void set_limit(logic [LIMIT_W-1:0] value);
         limit = value;
      endfunction

      function int unsigned pending();
         return replies_q.size();
      endfunction

      function void push(status_type st, logic [KEY_W-1:0] k, logic [KEY_W-1:0] p,
                         logic [KEY_W-1:0] i, logic last);
         table_reply_type r;
         r.status = st;
         r.key    = k;
         r.parent = p;
         r.info   = i;
         r.last   = last;
         replies_q.push_back(r);
      endfunction

      // apply one accepted request to the model, queue its responses
      function void note_request(op_type op, logic [KEY_W-1:0] key,
                                 logic [KEY_W-1:0] par, logic [KEY_W-1:0] info);
         int unsigned cap;
         int unsigned hole;
         int unsigned hits;
         bit          key_hit;
         bit          par_hit;
         bit          child_hit;
         status_type  st;
         key_hit   = 0;
         par_hit   = 0;
         child_hit = 0;
         hole      = 0;
         hits      = 0;
         for (int i = 0; i < count; i++) begin
            if (keys[i] == key) begin
               if (!key_hit) hole = i;
               key_hit = 1;
            end
            if (keys[i] == par) par_hit = 1;
            if (parents[i] == key) child_hit = 1;
         end
         case (op)
            OP_INSERT: begin
               cap = (limit < TABLE_DEPTH) ? limit : TABLE_DEPTH;
               if (count >= cap)
                  st = ST_FULL;
               else if (key_hit)
                  st = ST_DUPLICATE;
               else if (par != '0 && !par_hit)
                  st = ST_PARENT_MISSING;
               else begin
                  keys[count]    = key;
                  parents[count] = par;
                  infos[count]   = info;
                  count++;
                  st = ST_OK;
               end
               push(st, '0, '0, '0, 1'b1);
            end
            OP_DELETE: begin
               // children block the delete before absence is considered
               if (child_hit)
                  st = ST_HAS_CHILDREN;
               else if (!key_hit)
                  st = ST_NOT_FOUND;
               else begin
                  // last entry moves into the hole
                  keys[hole]    = keys[count-1];
                  parents[hole] = parents[count-1];
                  infos[hole]   = infos[count-1];
                  count--;
                  st = ST_OK;
               end
               push(st, '0, '0, '0, 1'b1);
            end
            OP_FIND: begin
               if (key_hit)
                  push(ST_OK, keys[hole], parents[hole], infos[hole], 1'b1);
               else
                  push(ST_NOT_FOUND, '0, '0, '0, 1'b1);
            end
            default: begin
               for (int i = 0; i < count; i++) begin
                  if (parents[i] == par) begin
                     push(ST_OK, keys[i], par, infos[i], 1'b0);
                     hits++;
                  end
               end
               if (hits == 0)
                  push(ST_NOT_FOUND, '0, '0, '0, 1'b1);
               else
                  replies_q[replies_q.size()-1].last = 1'b1;
            end
         endcase
      endfunction

      function void mismatch(string field, logic [KEY_W-1:0] want, logic [KEY_W-1:0] got);
         $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
         errors++;
      endfunction

      function void check_response(logic [STATUS_W-1:0] st, logic [3*KEY_W-1:0] data,
                                   logic last);
         table_reply_type want;
         if (replies_q.size() == 0) begin
            $display("%0t: unexpected response: expected none, actual status %0d key %h",
                     $time, st, data[KEY_W-1:0]);
            errors++;
            return;
         end
         want = replies_q.pop_front();
         if (st !== want.status)
            mismatch("status", 32'(want.status), 32'(st));
         if (data[KEY_W-1:0] !== want.key)
            mismatch("out_key", want.key, data[KEY_W-1:0]);
         if (data[2*KEY_W-1:KEY_W] !== want.parent)
            mismatch("out_parent", want.parent, data[2*KEY_W-1:KEY_W]);
         if (data[3*KEY_W-1:2*KEY_W] !== want.info)
            mismatch("out_info", want.info, data[3*KEY_W-1:2*KEY_W]);
         if (last !== want.last)
            mismatch("last", 32'(want.last), 32'(last));
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and block signals; every input is known from time zero
   // -------------------------------------------------------------------------
   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [3*KEY_W-1:0]     req_tdata  = '0;   // entry_key, parent_key, info_word
   logic [OP_W-1:0]        req_tuser  = '0;   // operation
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [3*KEY_W-1:0]     rsp_tdata;         // out_key, out_parent, out_info
   logic [STATUS_W-1:0]    rsp_tuser;         // status
   logic                   rsp_tlast;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [LIMIT_W-1:0]     csr_data   = '0;

   table_scoreboard_type   board = new();
   logic [KEY_W-1:0]       key_pool [KEY_POOL];
   int unsigned            requests_accepted = 0;
   bit                     pressure_done     = 0;
   bit                     steady;

   always #6 clock = ~clock;

   // a stretch of the run where neither stream idles
   assign steady = (requests_accepted >= 130) && (requests_accepted < 170);

   parent_linked_key_table #(
      .CAPACITY (TABLE_DEPTH)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // -------------------------------------------------------------------------
   // Request side
   // -------------------------------------------------------------------------
   // Offers one request transaction and returns in the step of its acceptance.
   // tvalid is left high so a back-to-back request never toggles it within a
   // step; idle gaps and the callers lower it.
   task automatic send_request(input op_type op, input logic [KEY_W-1:0] key,
                               input logic [KEY_W-1:0] par, input logic [KEY_W-1:0] info);
      while (!steady && $urandom_range(99) < 8) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {info, par, key};
      do @(posedge clock); while (!req_tready);
      board.note_request(op, key, par, info);
      requests_accepted++;
   endtask

   // Limit writes happen only with the table quiet: nothing offered and every
   // predicted response already received, plus some settle time.
   task automatic write_limit(input logic [LIMIT_W-1:0] value);
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      board.set_limit(value);
   endtask

   // Mostly pool keys so that duplicates, parents and children are common;
   // a few fully random keys and parents give misses and toggle every bit.
   task automatic random_request();
      op_type           op;
      logic [KEY_W-1:0] key;
      logic [KEY_W-1:0] par;
      int unsigned      roll;
      roll = $urandom_range(99);
      op   = (roll < 45) ? OP_INSERT : (roll < 65) ? OP_DELETE :
             (roll < 80) ? OP_FIND : OP_CHILDREN;
      key  = ($urandom_range(9) == 0) ? $urandom : key_pool[$urandom_range(KEY_POOL-1)];
      roll = $urandom_range(99);
      par  = (roll < 30) ? '0 :
             (roll < 90) ? key_pool[$urandom_range(KEY_POOL-1)] : $urandom;
      send_request(op, key, par, $urandom);
   endtask

   initial begin
      logic [LIMIT_W-1:0] phase_limits [6];
      phase_limits = '{5'd16, 5'd1, 5'd16, 5'd11, 5'd2, 5'd16};
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < KEY_POOL; i++) key_pool[i] = $urandom;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed opening at the reset limit
      send_request(OP_FIND,     32'd5,        '0,           '0);  // empty table
      send_request(OP_CHILDREN, '0,           '0,           '0);  // no children
      send_request(OP_DELETE,   32'd5,        '0,           '0);  // absent key
      send_request(OP_INSERT,   '0,           '0,           '1);  // key zero is legal
      send_request(OP_INSERT,   '1,           '0,           '0);
      send_request(OP_INSERT,   '0,           '1,           32'h1); // duplicate
      send_request(OP_INSERT,   32'd7,        32'd1234,     32'h2); // parent missing
      send_request(OP_INSERT,   32'd7,        '1,           32'h5);
      send_request(OP_INSERT,   32'd8,        '1,           32'hA5A5_5A5A);
      send_request(OP_INSERT,   32'd9,        '0,           32'h8000_0001);
      send_request(OP_CHILDREN, '0,           '1,           '0);  // two children
      send_request(OP_CHILDREN, '0,           '0,           '0);  // parentless ones
      send_request(OP_FIND,     32'd7,        '0,           '0);
      send_request(OP_FIND,     '1,           '0,           '0);
      send_request(OP_DELETE,   '1,           '0,           '0);  // has children
      send_request(OP_DELETE,   '0,           '0,           '0);  // parentless entries
      send_request(OP_DELETE,   32'd1234,     '0,           '0);  // not found
      send_request(OP_DELETE,   32'd7,        '0,           '0);  // hole filled by last
      send_request(OP_FIND,     32'd9,        '0,           '0);
      send_request(OP_CHILDREN, '0,           '1,           '0);

      // limit below the current entry count: entries stay, inserts refused
      write_limit(5'd3);
      send_request(OP_INSERT,   32'd20,       '0,           32'h3);
      send_request(OP_FIND,     32'd8,        '0,           '0);
      send_request(OP_DELETE,   32'd8,        '0,           '0);
      send_request(OP_INSERT,   32'd20,       '0,           32'h3);
      send_request(OP_INSERT,   32'd21,       32'd20,       32'h4);  // full again

      // random phases across a sweep of limits, both extremes included
      foreach (phase_limits[p]) begin
         write_limit(phase_limits[p]);
         repeat (PHASE_ITEMS) random_request();
      end

      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (board.errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Response side: sample at the edge, check, then choose the next tready.
   // One long hold-off lets the front queue fill and stall the request side.
   // -------------------------------------------------------------------------
   initial begin
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready)
            board.check_response(rsp_tuser, rsp_tdata, rsp_tlast);
         if (!pressure_done && requests_accepted >= 60) begin
            pressure_done = 1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_tready <= steady || ($urandom_range(99) >= 8);
      end
   end

   // watchdog
   initial begin
      #3_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
